FILE: rtl/sync_header_image_frame_receiver_unit_macros.svh
// assertion macros used by the receiver top level
`ifndef SYNC_HEADER_IMAGE_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SYNC_HEADER_IMAGE_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHFR_ASSERT_SAME(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHFR_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/shfr_pkg.sv
// shared types and constants of the sync-framed image receiver
package shfr_pkg;

  localparam logic [7:0] SYNC_LEAD  = 8'hAA;
  localparam logic [7:0] SYNC_TAIL  = 8'h55;
  localparam logic [7:0] REPLY_ACK  = 8'h06;
  localparam logic [7:0] REPLY_NACK = 8'h15;
  localparam logic [7:0] REPLY_NONE = 8'h00;

  localparam int DIM_W  = 10;
  localparam int AREA_W = 2 * DIM_W;
  localparam int WORD_W = 16;

  localparam logic [DIM_W-1:0] LIMIT_RESET = 10'd320;

  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_NACK  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_MAX_WIDTH  = 1'b0,
    REG_MAX_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             we;
    logic [0:0]       index;
    logic [DIM_W-1:0] data;
  } cfg_wr_t;

  // classified request from the parser to the result stage
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] pixel;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic              last;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        reply_byte;
    logic [WORD_W-1:0] pixel;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic              last_pixel;
    logic              end_of_run;
  } res_t;

endpackage

FILE: rtl/shfr_front.sv
// byte parser: sync hunt, header check, pixel assembly
module shfr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  shfr_pkg::cfg_wr_t         cfg,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  output logic                      cmd_push,
  output shfr_pkg::cmd_t            cmd
);

  typedef enum logic [7:0] {
    ST_HUNT      = 8'b0000_0001,
    ST_SYNC_SEEN = 8'b0000_0010,
    ST_W_HI      = 8'b0000_0100,
    ST_W_LO      = 8'b0000_1000,
    ST_H_HI      = 8'b0001_0000,
    ST_H_LO      = 8'b0010_0000,
    ST_PIX_HI    = 8'b0100_0000,
    ST_PIX_LO    = 8'b1000_0000
  } state_t;

  state_t                            state, state_next;
  logic [7:0]                        hold, hold_next;
  logic [shfr_pkg::WORD_W-1:0]       width, width_next;
  logic [shfr_pkg::AREA_W-1:0]       left, left_next;
  logic [shfr_pkg::DIM_W-1:0]        max_width, max_height;
  logic [shfr_pkg::WORD_W-1:0]       word;
  logic [shfr_pkg::AREA_W-1:0]       area;
  logic [shfr_pkg::AREA_W-1:0]       left_dec;
  logic                              reject;

  assign word     = {hold, rx_byte};
  assign area     = shfr_pkg::AREA_W'(width[shfr_pkg::DIM_W-1:0])
                  * shfr_pkg::AREA_W'(word[shfr_pkg::DIM_W-1:0]);
  assign left_dec = left - shfr_pkg::AREA_W'(1);
  assign reject   = (width == '0) || (word == '0)
                  || (width > shfr_pkg::WORD_W'(max_width))
                  || (word > shfr_pkg::WORD_W'(max_height));

  always_comb begin
    state_next = state;
    hold_next  = hold;
    width_next = width;
    left_next  = left;
    cmd_push   = 1'b0;
    cmd        = '0;
    if (accept) begin
      case (state)
        ST_HUNT: begin
          if (rx_byte == shfr_pkg::SYNC_LEAD) state_next = ST_SYNC_SEEN;
        end
        ST_SYNC_SEEN: begin
          if (rx_byte == shfr_pkg::SYNC_TAIL) state_next = ST_W_HI;
          else if (rx_byte == shfr_pkg::SYNC_LEAD) state_next = ST_SYNC_SEEN;
          else state_next = ST_HUNT;
        end
        ST_W_HI: begin
          hold_next  = rx_byte;
          state_next = ST_W_LO;
        end
        ST_W_LO: begin
          width_next = word;
          state_next = ST_H_HI;
        end
        ST_H_HI: begin
          hold_next  = rx_byte;
          state_next = ST_H_LO;
        end
        ST_H_LO: begin
          cmd_push = 1'b1;
          if (reject) begin
            cmd.kind   = shfr_pkg::KIND_NACK;
            state_next = ST_HUNT;
          end else begin
            cmd.kind         = shfr_pkg::KIND_ACK;
            cmd.frame_width  = width[shfr_pkg::DIM_W-1:0];
            cmd.frame_height = word[shfr_pkg::DIM_W-1:0];
            left_next        = area;
            state_next       = ST_PIX_HI;
          end
        end
        ST_PIX_HI: begin
          hold_next  = rx_byte;
          state_next = ST_PIX_LO;
        end
        ST_PIX_LO: begin
          cmd_push   = 1'b1;
          cmd.kind   = shfr_pkg::KIND_PIXEL;
          cmd.pixel  = word;
          cmd.last   = (left_dec == '0);
          left_next  = left_dec;
          state_next = (left_dec == '0) ? ST_HUNT : ST_PIX_HI;
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_HUNT;
      left       <= '0;
      max_width  <= shfr_pkg::LIMIT_RESET;
      max_height <= shfr_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;
      left  <= left_next;
      if (cfg.we && cfg.index == shfr_pkg::REG_MAX_WIDTH) max_width <= cfg.data;
      if (cfg.we && cfg.index == shfr_pkg::REG_MAX_HEIGHT) max_height <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    hold  <= hold_next;
    width <= width_next;
  end

endmodule

FILE: rtl/shfr_cmdq.sv
// short request queue between parser and result stage
module shfr_cmdq #(
  parameter int DEPTH = shfr_pkg::CMDQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  shfr_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output shfr_pkg::cmd_t pop_data,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  shfr_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/shfr_back.sv
// result stage: expands requests into results, one per cycle unless stalled, output register
module shfr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  shfr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output shfr_pkg::res_t res,
  input  logic           res_pop
);

  logic           load;
  logic           second, second_next;
  shfr_pkg::res_t res_next;

  assign load = cmd_valid && (!res_valid || res_pop);

  always_comb begin
    res_next              = '0;
    res_next.kind         = cmd.kind;
    res_next.pixel        = cmd.pixel;
    res_next.frame_width  = cmd.frame_width;
    res_next.frame_height = cmd.frame_height;
    res_next.end_of_run   = 1'b1;
    second_next           = second;
    cmd_pop               = 1'b0;
    case (cmd.kind)
      shfr_pkg::KIND_ACK:  res_next.reply_byte = shfr_pkg::REPLY_ACK;
      shfr_pkg::KIND_NACK: res_next.reply_byte = shfr_pkg::REPLY_NACK;
      shfr_pkg::KIND_DONE: res_next.reply_byte = shfr_pkg::REPLY_ACK;
      default:             res_next.reply_byte = shfr_pkg::REPLY_NONE;
    endcase
    if (load) begin
      if (second) begin
        // frame-done reply after the final pixel
        res_next            = '0;
        res_next.kind       = shfr_pkg::KIND_DONE;
        res_next.reply_byte = shfr_pkg::REPLY_ACK;
        res_next.end_of_run = 1'b1;
        second_next         = 1'b0;
        cmd_pop             = 1'b1;
      end else if (cmd.kind == shfr_pkg::KIND_PIXEL && cmd.last) begin
        res_next.last_pixel = 1'b1;
        res_next.end_of_run = 1'b0;
        second_next         = 1'b1;
      end else begin
        cmd_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

endmodule

FILE: rtl/sync_header_image_frame_receiver_unit.sv
// top level of the sync-framed image receiver
// usage:
//   input side is a queue: drive rx_byte with push; a byte is taken at an
//   edge where push is high and full is low. one byte per cycle unless full.
//   result side is a queue: while empty is low the oldest result sits on
//   kind/reply_byte/pixel/frame_width/frame_height/last_pixel/end_of_run,
//   and pop at an edge with empty low takes it.
//   max_width / max_height are written through cfg_we, cfg_index, cfg_data
//   while the block is idle; both come out of reset at 320.
// timing:
//   a byte that causes a result is written into the request queue at its
//   accept edge; the result register loads it from the queue head once
//   that register is free. while pop stays high, results leave at one per
//   cycle; the final pixel of a frame yields two results in turn.
//   throughput is set by the single result register: one result per cycle.
// stall:
//   when pop stays low the request queue fills and full rises; bytes are
//   held off, nothing is dropped.
// reset:
//   synchronous rst returns the parser to the sync hunt, empties the queue
//   and the result register, and restores both limits.
module sync_header_image_frame_receiver_unit #(
  parameter int CMDQ_DEPTH = shfr_pkg::CMDQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // byte input queue
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte,
  // limit registers
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [shfr_pkg::DIM_W-1:0]   cfg_data,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   kind,
  output logic [7:0]                   reply_byte,
  output logic [shfr_pkg::WORD_W-1:0]  pixel,
  output logic [shfr_pkg::DIM_W-1:0]   frame_width,
  output logic [shfr_pkg::DIM_W-1:0]   frame_height,
  output logic                         last_pixel,
  output logic                         end_of_run
);

  `include "sync_header_image_frame_receiver_unit_macros.svh"

  shfr_pkg::cfg_wr_t cfg;
  shfr_pkg::cmd_t    front_cmd, head_cmd;
  shfr_pkg::res_t    res;
  logic              accept;
  logic              front_push;
  logic              cmdq_full, cmdq_empty, cmdq_pop;
  logic              res_valid, res_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // byte request taken only when the queue has room for what it may cause
  assign full   = cmdq_full;
  assign accept = push && !cmdq_full;

  shfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  shfr_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (cmdq_full),
    .pop       (cmdq_pop),
    .pop_data  (head_cmd),
    .empty     (cmdq_empty)
  );

  shfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmdq_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmdq_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (res_pop)
  );

  // result queue face
  assign empty        = !res_valid;
  assign res_pop      = pop && res_valid;
  assign kind         = res.kind;
  assign reply_byte   = res.reply_byte;
  assign pixel        = res.pixel;
  assign frame_width  = res.frame_width;
  assign frame_height = res.frame_height;
  assign last_pixel   = res.last_pixel;
  assign end_of_run   = res.end_of_run;

  // parser never pushes into a full request queue
  `SHFR_ASSERT_SAME(a_no_push_full, clk, rst, front_push, !cmdq_full, "push into full queue")
  // a popped final pixel is followed at once by the frame-done reply
  `SHFR_ASSERT_NEXT(a_done_follows, clk, rst, res_pop && res.last_pixel, res_valid && res.kind == shfr_pkg::KIND_DONE, "frame done missing")
  // only the final pixel leaves a byte's run open
  `SHFR_ASSERT_SAME(a_open_run, clk, rst, res_valid && !res.end_of_run, res.kind == shfr_pkg::KIND_PIXEL && res.last_pixel, "open run on wrong result")
  // an accepted header never carries a zero dimension
  `SHFR_ASSERT_SAME(a_ack_dims, clk, rst, res_valid && res.kind == shfr_pkg::KIND_ACK, res.frame_width != '0 && res.frame_height != '0, "zero size ack")

endmodule
